>>> rtl/fixed_huffman_byte_packer_defines.svh
// ----------------------------------------------------------------------------
// Fixed Huffman byte packer: assertion macros
// Shared property forms used by the packer's checks.
// ----------------------------------------------------------------------------
`ifndef FIXED_HUFFMAN_BYTE_PACKER_DEFINES_SVH
`define FIXED_HUFFMAN_BYTE_PACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FHBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FHBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fhbp_pkg.sv
// ----------------------------------------------------------------------------
// fhbp_pkg
// Types, code table and constants of the fixed Huffman byte packer.
// ----------------------------------------------------------------------------
`default_nettype none

package fhbp_pkg;

  // number of symbols that have a code
  localparam logic [3:0] NUM_CODES = 4'd13;

  // one input item
  typedef struct packed {
    logic [3:0] symbol;
    logic       flush;
  } item_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } res_t;

  // code bits, right-aligned
  function automatic logic [6:0] code_bits(input logic [3:0] sym);
    logic [6:0] bits;
    begin
      case (sym)
        4'd0:    bits = 7'h07;
        4'd1:    bits = 7'h0d;
        4'd2:    bits = 7'h0b;
        4'd3:    bits = 7'h11;
        4'd4:    bits = 7'h09;
        4'd5:    bits = 7'h31;
        4'd6:    bits = 7'h33;
        4'd7:    bits = 7'h60;
        4'd8:    bits = 7'h32;
        4'd9:    bits = 7'h61;
        4'd10:   bits = 7'h0a;
        4'd11:   bits = 7'h10;
        4'd12:   bits = 7'h00;
        default: bits = 7'h00;
      endcase
      return bits;
    end
  endfunction

  // code length in bits, 1 to 7
  function automatic logic [2:0] code_len(input logic [3:0] sym);
    logic [2:0] len;
    begin
      case (sym)
        4'd0:    len = 3'd3;
        4'd1:    len = 3'd4;
        4'd2:    len = 3'd4;
        4'd3:    len = 3'd5;
        4'd4:    len = 3'd4;
        4'd5:    len = 3'd6;
        4'd6:    len = 3'd6;
        4'd7:    len = 3'd7;
        4'd8:    len = 3'd6;
        4'd9:    len = 3'd7;
        4'd10:   len = 3'd4;
        4'd11:   len = 3'd5;
        4'd12:   len = 3'd1;
        default: len = 3'd1;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/fhbp_in_stage.sv
// ----------------------------------------------------------------------------
// fhbp_in_stage
// Input register: captures one item and hands it to the packer.
// ----------------------------------------------------------------------------
`default_nettype none

module fhbp_in_stage import fhbp_pkg::*; (
  input  wire   clk,
  input  wire   rst,
  input  wire   in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  wire   advance,
  output logic  item_valid,
  output item_t item
);

  // stage takes a new item when empty or when its item moves on
  assign in_ready = !item_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fhbp_packer.sv
// ----------------------------------------------------------------------------
// fhbp_packer
// Code lookup, bit accumulator and byte extraction; one item per fired cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_huffman_byte_packer_defines.svh"

module fhbp_packer import fhbp_pkg::*; (
  input  wire   clk,
  input  wire   rst,
  input  wire   fire,
  input  item_t item,
  output logic  res_valid,
  output res_t  res
);

  logic [6:0]  pending_bits;
  logic [2:0]  pending_count;
  logic [6:0]  pending_bits_next;
  logic [2:0]  pending_count_next;

  logic [6:0]  code;
  logic [2:0]  len;
  logic [13:0] acc;
  logic [3:0]  total;
  logic [2:0]  rem;
  logic [13:0] acc_shr;
  logic [14:0] pad;
  logic [6:0]  rem_mask;

  // table lookup and append
  always_comb begin
    code     = code_bits(item.symbol);
    len      = code_len(item.symbol);
    acc      = ({7'd0, pending_bits} << len) | {7'd0, code};
    total    = {1'b0, pending_count} + {1'b0, len};
    rem      = total[2:0];
    acc_shr  = acc >> rem;
    rem_mask = ~(7'h7f << rem);
    pad      = {pending_bits, 8'd0} >> pending_count;
  end

  // next state and result
  always_comb begin
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    res_valid          = 1'b0;
    res.out_byte       = acc_shr[7:0];
    res.last           = 1'b0;
    if (fire) begin
      if (item.flush) begin
        // pad pending bits with zeros below, emit only if any pending
        res.out_byte       = pad[7:0];
        res.last           = 1'b1;
        res_valid          = (pending_count != 3'd0);
        pending_bits_next  = 7'd0;
        pending_count_next = 3'd0;
      end else if (item.symbol < NUM_CODES) begin
        if (total[3]) begin
          // a full byte gathered, keep the remainder
          res_valid          = 1'b1;
          pending_bits_next  = acc[6:0] & rem_mask;
          pending_count_next = rem;
        end else begin
          pending_bits_next  = acc[6:0];
          pending_count_next = total[2:0];
        end
      end
    end
  end

  // accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= 7'd0;
      pending_count <= 3'd0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

  // checks
  `FHBP_ASSERT_NEXT(a_flush_empties, fire && item.flush,
    (pending_count == 3'd0) && (pending_bits == 7'd0), "flush left bits pending")
  `FHBP_ASSERT_NEXT(a_drop_keeps_state, fire && !item.flush && (item.symbol >= NUM_CODES),
    $stable(pending_count) && $stable(pending_bits), "dropped symbol changed state")
  `FHBP_ASSERT_NOW(a_clean_high_bits, 1'b1,
    (pending_bits >> pending_count) == 7'd0, "bits above pending count not zero")

endmodule

`default_nettype wire

>>> rtl/fhbp_out_stage.sv
// ----------------------------------------------------------------------------
// fhbp_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fhbp_out_stage import fhbp_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  res_valid,
  input  res_t res,
  output logic can_load,
  output logic out_valid,
  input  wire  out_ready,
  output res_t out_res
);

  // register may load when empty or being drained
  assign can_load = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= res_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (can_load && res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fixed_huffman_byte_packer.sv
// Fixed Huffman byte packer: encodes symbols 0 to 12 with a fixed prefix code
// of 1 to 7 bits, packs the codes MSB first and emits a byte whenever eight
// bits have gathered; a flush item pads the pending bits with zeros and emits
// them as a byte marked last (nothing if no bits are pending), and symbols 13
// to 15 are dropped. The block accepts one item every cycle while the
// consumer is not stalling the result register; an accepted item passes
// through the input register and then the result register before its
// result is on the output, and each item yields at most one result, so a
// stalled consumer holds back input only through ready.
// ----------------------------------------------------------------------------
// fixed_huffman_byte_packer
// Top level: input register, packer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_huffman_byte_packer import fhbp_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [3:0] symbol,
  input  wire        flush,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_byte,
  output logic       last
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  advance;
  logic  res_valid;
  res_t  res;
  res_t  out_res;

  // input item assembly
  assign in_item.symbol = symbol;
  assign in_item.flush  = flush;

  fhbp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  fhbp_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .fire      (item_valid && advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  fhbp_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // result fields
  assign out_byte = out_res.out_byte;
  assign last     = out_res.last;

endmodule

`default_nettype wire
